### rtl/core/glpf_pkg.sv
// ----------------------------------------------------------------------------
// glpf_pkg: shared types and constants of the grid local peak finder
// Register map, configuration field widths and the control state type.
// ----------------------------------------------------------------------------
`default_nettype none

package glpf_pkg;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // configuration register fields
  localparam int CFG_ROWS_W = 11;
  localparam int CFG_COLS_W = 6;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // control sequencer
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } glpf_state_e;

endpackage : glpf_pkg

`default_nettype wire

### rtl/core/grid_local_peak_finder.sv
// ----------------------------------------------------------------------------
// grid_local_peak_finder: 4-neighbor local maximum detection on a streamed grid
// Cells arrive row-major; each cell of the row above is judged when the cell
// below it arrives, and the last cell of a frame flushes the last row.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while streaming a frame and the output is not stalled.
// Order: a peak of row r-1 appears on the output the cycle after the word
//   below it is taken. The final word of a frame holds its peak and starts a
//   flush of the last row through the row chains, with input stalled.
// Reset: num_rows = num_cols = 1, row and column position zero, output empty.
//   The row chains are not reset; a new frame never reads stale contents.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_peak_finder
  import glpf_pkg::*;
#(
  parameter int MAX_COLS   = 32,
  parameter int MAX_ROWS   = 1024,
  parameter int DATA_WIDTH = 16,
  localparam int IN_TW     = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int OUT_TW    = ((ROW_W + COL_W + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_TW-1:0]  s_axis_tdata,   // [DATA_WIDTH-1:0] height_value
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_TW-1:0] m_axis_tdata,   // peak_row, then peak_col, zero pad
  output logic                   m_axis_tlast,   // last_of_run
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_ROWS_W-1:0] num_rows_q;
  logic [CFG_COLS_W-1:0] num_cols_q;
  logic                  cfg_wr;
  logic                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_ROWS_W'(1);
      num_cols_q <= CFG_COLS_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_ROWS: num_rows_q <= pwdata[CFG_ROWS_W-1:0];
        REG_NUM_COLS: num_cols_q <= pwdata[CFG_COLS_W-1:0];
        default:      num_rows_q <= num_rows_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_ROWS: prdata = APB_DW'(num_rows_q);
      REG_NUM_COLS: prdata = APB_DW'(num_cols_q);
      default:      prdata = '0;
    endcase
  end

  // saturated frame geometry, as last index
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;

  always_comb begin
    if (num_rows_q == '0) begin
      last_row = '0;
    end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(num_rows_q - 1'b1);
    end
    if (num_cols_q == '0) begin
      last_col = '0;
    end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(num_cols_q - 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // row chains: A holds the last num_cols words, B the row before them
  // --------------------------------------------------------------------------
  logic                         chain_shift;
  logic                         rotate;
  logic        [DATA_WIDTH-1:0] a_ins;
  logic        [DATA_WIDTH-1:0] b_ins;
  logic signed [DATA_WIDTH-1:0] a_head;
  logic signed [DATA_WIDTH-1:0] a_second;
  logic signed [DATA_WIDTH-1:0] b_head;
  logic        [DATA_WIDTH-1:0] b_second;
  logic signed [DATA_WIDTH-1:0] left_q;
  logic signed [DATA_WIDTH-1:0] key;

  assign key = s_axis_tdata[DATA_WIDTH-1:0];

  // streaming feeds the new word; the flush rotates each chain onto itself
  assign a_ins = rotate ? a_head : key;
  assign b_ins = rotate ? b_head : a_head;

  glpf_row_chain #(
    .DW    (DATA_WIDTH),
    .DEPTH (MAX_COLS),
    .IDX_W (COL_W)
  ) u_chain_a (
    .clk_i      (clk_i),
    .shift_i    (chain_shift),
    .last_idx_i (last_col),
    .ins_i      (a_ins),
    .head_o     (a_head),
    .second_o   (a_second)
  );

  glpf_row_chain #(
    .DW    (DATA_WIDTH),
    .DEPTH (MAX_COLS),
    .IDX_W (COL_W)
  ) u_chain_b (
    .clk_i      (clk_i),
    .shift_i    (chain_shift),
    .last_idx_i (last_col),
    .ins_i      (b_ins),
    .head_o     (b_head),
    .second_o   (b_second)
  );

  // left neighbor: the head word before the previous shift
  always_ff @(posedge clk_i) begin
    if (chain_shift) begin
      left_q <= a_head;
    end
  end

  // --------------------------------------------------------------------------
  // control and peak tests
  // --------------------------------------------------------------------------
  glpf_state_e      state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] fcnt_q, fcnt_d;
  logic             pend_vld_q, pend_vld_d;
  logic [ROW_W-1:0] pend_row_q, pend_row_d;
  logic [COL_W-1:0] pend_col_q, pend_col_d;
  logic             out_vld_q, out_vld_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  logic             in_fire;
  logic             final_cell;
  logic             s_peak;
  logic             f_peak;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_RUN) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign final_cell    = (row_q == last_row) && (col_q == last_col);

  // cell above the arriving word: head of A, neighbors left/right/up/down
  assign s_peak = (row_q != '0) &&
                  !(((col_q != '0) && (a_head < left_q)) ||
                    ((col_q != last_col) && (a_head < a_second)) ||
                    ((row_q > ROW_W'(1)) && (a_head < b_head)) ||
                    (a_head < key));

  // last row during flush: no row below
  assign f_peak = !(((fcnt_q != '0) && (a_head < left_q)) ||
                    ((fcnt_q != last_col) && (a_head < a_second)) ||
                    ((last_row != '0) && (a_head < b_head)));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    fcnt_d      = fcnt_q;
    pend_vld_d  = pend_vld_q;
    pend_row_d  = pend_row_q;
    pend_col_d  = pend_col_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    chain_shift = 1'b0;
    rotate      = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          chain_shift = 1'b1;
          if (final_cell) begin
            // hold this peak until the flush shows whether it is the last
            if (s_peak) begin
              pend_vld_d = 1'b1;
              pend_row_d = row_q - 1'b1;
              pend_col_d = col_q;
            end
            fcnt_d  = '0;
            row_d   = '0;
            col_d   = '0;
            state_d = ST_FLUSH;
          end else begin
            if (s_peak) begin
              out_vld_d  = 1'b1;
              out_row_d  = row_q - 1'b1;
              out_col_d  = col_q;
              out_last_d = 1'b1;
            end
            if (col_q == last_col) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          chain_shift = 1'b1;
          rotate      = 1'b1;
          if (f_peak) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_row_d  = pend_row_q;
              out_col_d  = pend_col_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_row_d = last_row;
            pend_col_d = fcnt_q;
          end
          if (fcnt_q == last_col) begin
            state_d = ST_DRAIN;
          end else begin
            fcnt_d = fcnt_q + 1'b1;
          end
        end
      end

      ST_DRAIN: begin
        // the held peak closes the run
        if (out_free) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_row_d  = pend_row_q;
            out_col_d  = pend_col_q;
            out_last_d = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_RUN;
        end
      end

      default: state_d = ST_RUN;
    endcase

    // any register write restarts the frame
    if (cfg_wr) begin
      row_d = '0;
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      row_q      <= '0;
      col_q      <= '0;
      fcnt_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      fcnt_q     <= fcnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TW'({out_col_q, out_row_q});
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_final_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && final_cell |=> state_q == ST_FLUSH)
    else $error("final word did not start the row flush");

  a_flush_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> fcnt_q <= last_col)
    else $error("flush index beyond row length");

  a_drain_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN && out_free |=> !pend_vld_q && state_q == ST_RUN)
    else $error("held peak left after drain");

  a_open_run_only_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_last_q |-> state_q == ST_FLUSH || state_q == ST_DRAIN)
    else $error("open run outside the flush");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col)
    else $error("column position beyond row length");

endmodule : grid_local_peak_finder

`default_nettype wire

### rtl/core/glpf_cell.sv
// ----------------------------------------------------------------------------
// glpf_cell: one storage cell of a row delay chain
// Holds one height; on a shift it takes its neighbor's value, or the chain
// input when it is the tail of the active row length.
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_cell #(
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          shift_i,
  input  wire logic          tail_i,
  input  wire logic [DW-1:0] ins_i,
  input  wire logic [DW-1:0] next_i,
  output logic      [DW-1:0] data_o
);

  logic [DW-1:0] data_q;
  logic [DW-1:0] data_d;

  // tail cell loads the new word, others move one place toward the head
  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = tail_i ? ins_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : glpf_cell

`default_nettype wire

### rtl/core/glpf_row_chain.sv
// ----------------------------------------------------------------------------
// glpf_row_chain: programmable-length delay line of one grid row
// A row of cells; the word entering at the tail leaves the head after
// last_idx+1 shifts. Head and the cell behind it are tapped.
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_row_chain #(
  parameter int DW    = 16,
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic [IDX_W-1:0] last_idx_i,
  input  wire logic [DW-1:0]    ins_i,
  output logic      [DW-1:0]    head_o,
  output logic      [DW-1:0]    second_o
);

  logic [DW-1:0] cell_data [DEPTH];

  // cells, each fed by its neighbor toward the tail
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DW-1:0] next_w;
    logic          tail_w;

    if (k == DEPTH - 1) begin : g_end
      assign next_w = cell_data[k];
    end else begin : g_mid
      assign next_w = cell_data[k+1];
    end

    assign tail_w = (last_idx_i == IDX_W'(k));

    glpf_cell #(
      .DW (DW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .tail_i  (tail_w),
      .ins_i   (ins_i),
      .next_i  (next_w),
      .data_o  (cell_data[k])
    );
  end

  assign head_o = cell_data[0];

  // right-hand neighbor tap; unused when the row is one cell long
  if (DEPTH > 1) begin : g_second
    assign second_o = cell_data[1];
  end else begin : g_no_second
    assign second_o = cell_data[0];
  end

endmodule : glpf_row_chain

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the grid local peak finder
// Heights stream in row-major order. A directed table is walked first, then
// random frames are sent over many grid shapes and handshake idling modes. An
// in-bench predictor tracks the three row stores and the grid position, and
// each peak word is checked against the oldest predicted peak.
// ----------------------------------------------------------------------------

module tb;
  import glpf_pkg::*;

  localparam int GRID_COLS     = 32;
  localparam int GRID_ROWS     = 1024;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_TARGET = 388;
  localparam int OPEN_CELLS    = 40;
  localparam int SETTLE_CYCLES = 40;
  localparam int N_DIR         = 33;

  // roles of the three row stores in the predictor
  localparam int ROW_NONE  = -1;
  localparam int ROW_ABOVE = 0;
  localparam int ROW_MID   = 1;
  localparam int ROW_CUR   = 2;

  typedef enum logic [1:0] {
    DIR_CELL,
    DIR_ROWS,
    DIR_COLS
  } dir_op_e;

  // one line of the directed table; a peak is typed in only where obvious
  typedef struct packed {
    dir_op_e            op;
    logic signed [31:0] value;
    logic               typed;
    logic               typed_hit;
    logic [9:0]         typed_row;
    logic [4:0]         typed_col;
  } dir_step_t;

  typedef struct packed {
    logic [9:0] row;
    logic [4:0] col;
    logic       tlast_bit;
  } peak_t;

  // DUT connections
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;    // [15:0] height_value
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;          // [9:0] peak_row, [14:10] peak_col
  logic              m_axis_tlast;          // last_of_run
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // typed expectation riding along with the current word
  logic       item_typed = 1'b0;
  logic       item_hit   = 1'b0;
  logic [9:0] item_row   = '0;
  logic [4:0] item_col   = '0;

  // predictor state
  logic signed [15:0] grid_rows [3][GRID_COLS];
  int unsigned        cfg_rows = 1;
  int unsigned        cfg_cols = 1;
  int                 row_pos  = 0;
  int                 col_pos  = 0;
  peak_t              fresh_peaks [$];
  peak_t              peak_expect [$];

  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int heights_sent  = 0;
  int peaks_seen    = 0;
  int cycle_count   = 0;

  dir_step_t directed [N_DIR] = '{
    // out of reset the grid is a single cell: every word is its own peak
    '{DIR_CELL, 32767,  1'b1, 1'b1, 10'd0, 5'd0},
    '{DIR_CELL, -32768, 1'b1, 1'b1, 10'd0, 5'd0},
    // zero sizes clamp to one
    '{DIR_ROWS, 0,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 0,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 0,      1'b1, 1'b1, 10'd0, 5'd0},
    // single row: nothing until the last word flushes the row
    '{DIR_ROWS, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 4,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -32768, 1'b1, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 32767,  1'b1, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 32767,  1'b1, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -5,     1'b0, 1'b0, 10'd0, 5'd0},
    // single column
    '{DIR_ROWS, 3,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 5,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 5,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -1,     1'b0, 1'b0, 10'd0, 5'd0},
    // partial frame, then a register write restarts it
    '{DIR_ROWS, 2,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 3,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 2,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 3,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 7,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 7,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, 1,      1'b0, 1'b0, 10'd0, 5'd0},
    // flat 2x2 plateau: all four cells are peaks
    '{DIR_ROWS, 2,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_COLS, 2,      1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -7,     1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -7,     1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -7,     1'b0, 1'b0, 10'd0, 5'd0},
    '{DIR_CELL, -7,     1'b0, 1'b0, 10'd0, 5'd0}
  };

  grid_local_peak_finder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_size(int unsigned v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // cell c of row store mid is >= every existing 4-neighbor
  function automatic bit is_top(int mid, int up, int dn, int c, int nc);
    logic signed [15:0] v;
    v = grid_rows[mid][c];
    if (c > 0 && v < grid_rows[mid][c-1]) return 1'b0;
    if (c + 1 < nc && v < grid_rows[mid][c+1]) return 1'b0;
    if (up != ROW_NONE && v < grid_rows[up][c]) return 1'b0;
    if (dn != ROW_NONE && v < grid_rows[dn][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_peak(int r, int c);
    peak_t pk;
    pk.row       = 10'(r);
    pk.col       = 5'(c);
    pk.tlast_bit = 1'b0;
    fresh_peaks.push_back(pk);
  endfunction

  // take one height, advance the grid position, collect the peaks it causes
  function automatic void predict_heights(logic signed [15:0] h);
    int    nr;
    int    nc;
    int    r;
    int    c;
    peak_t tail;
    fresh_peaks.delete();
    nr = clamp_size(cfg_rows, GRID_ROWS);
    nc = clamp_size(cfg_cols, GRID_COLS);
    r  = (row_pos < nr) ? row_pos : nr - 1;
    c  = (col_pos < nc) ? col_pos : nc - 1;
    grid_rows[ROW_CUR][c] = h;
    // the cell right above is complete now
    if (r >= 1 && is_top(ROW_MID, (r >= 2) ? ROW_ABOVE : ROW_NONE, ROW_CUR, c, nc))
      note_peak(r - 1, c);
    if (r == nr - 1 && c == nc - 1) begin
      // end of frame: flush the last row
      for (int j = 0; j < nc; j++)
        if (is_top(ROW_CUR, (r >= 1) ? ROW_MID : ROW_NONE, ROW_NONE, j, nc))
          note_peak(r, j);
      row_pos = 0;
      col_pos = 0;
    end else if (c + 1 < nc) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      for (int j = 0; j < GRID_COLS; j++) begin
        grid_rows[ROW_ABOVE][j] = grid_rows[ROW_MID][j];
        grid_rows[ROW_MID][j]   = grid_rows[ROW_CUR][j];
      end
      col_pos = 0;
      row_pos = r + 1;
    end
    if (fresh_peaks.size() > 0) begin
      tail           = fresh_peaks.pop_back();
      tail.tlast_bit = 1'b1;
      fresh_peaks.push_back(tail);
    end
  endfunction

  function automatic void flag_error(string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, what);
  endfunction

  // ------------------------------------------------------------- scoreboard

  always @(posedge clk_i) begin : scoreboard
    peak_t want;
    peak_t typed_pk;
    if (rst_ni) begin
      // result side first: a peak never shows up in the cycle of its word
      if (m_axis_tvalid && m_axis_tready) begin
        peaks_seen++;
        if (peak_expect.size() == 0) begin
          flag_error($sformatf("unexpected peak row %0d col %0d last %0b",
                               m_axis_tdata[9:0], m_axis_tdata[14:10], m_axis_tlast));
        end else begin
          want = peak_expect.pop_front();
          if (m_axis_tdata[9:0] != want.row || m_axis_tdata[14:10] != want.col ||
              m_axis_tlast != want.tlast_bit)
            flag_error($sformatf("peak exp row %0d col %0d last %0b, got %0d %0d %0b",
                                 want.row, want.col, want.tlast_bit, m_axis_tdata[9:0],
                                 m_axis_tdata[14:10], m_axis_tlast));
        end
      end
      // register write restarts the frame
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NUM_COLS) cfg_cols = pwdata[CFG_COLS_W-1:0];
        else cfg_rows = pwdata[CFG_ROWS_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_heights(s_axis_tdata);
        if (item_typed) begin
          if (item_hit) begin
            typed_pk.row       = item_row;
            typed_pk.col       = item_col;
            typed_pk.tlast_bit = 1'b1;
            peak_expect.push_back(typed_pk);
          end
        end else begin
          foreach (fresh_peaks[k]) peak_expect.push_back(fresh_peaks[k]);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d peaks outstanding", cycle_count,
               peak_expect.size());
      $display("grid_local_peak_finder test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------- drivers

  // all driver tasks are entered and left just after a falling edge

  task automatic push_cell(input logic signed [15:0] h, input logic typed,
                           input logic hit, input logic [9:0] r, input logic [4:0] c);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    item_typed    <= typed;
    item_hit      <= hit;
    item_row      <= r;
    item_col      <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    heights_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every predicted peak is out, then idle a while
  task automatic hold_input(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (peak_expect.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_register(input logic which, input int unsigned value);
    logic [APB_DW-1:0] readback;
    int unsigned       shadow;
    hold_input(SETTLE_CYCLES);
    // write: setup then access
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    // read it back
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    shadow = (which == REG_NUM_COLS) ? cfg_cols : cfg_rows;
    if (readback != shadow)
      flag_error($sformatf("register %0d read %0d, exp %0d", which, readback, shadow));
  endtask

  function automatic logic signed [15:0] rand_height(int style);
    logic signed [15:0] h;
    case (style)
      0: h = 16'($urandom);
      1: h = 16'(int'($urandom_range(6)) - 3);   // narrow range: plateaus and ties
      default: begin
        case ($urandom_range(3))
          0:       h = 16'sh8000;
          1:       h = 16'sh7fff;
          2:       h = 16'sh0000;
          default: h = 16'shffff;
        endcase
      end
    endcase
    return h;
  endfunction

  // -------------------------------------------------------------- stimulus

  initial begin : stimulus
    int          phase;
    int          mode;
    int          random_sent;
    int          fsize;
    int          nframes;
    int          cut;
    int unsigned rows_w;
    int unsigned cols_w;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      case (directed[i].op)
        DIR_ROWS: write_register(REG_NUM_ROWS, directed[i].value);
        DIR_COLS: write_register(REG_NUM_COLS, directed[i].value);
        default:  push_cell(directed[i].value[15:0], directed[i].typed,
                            directed[i].typed_hit, directed[i].typed_row,
                            directed[i].typed_col);
      endcase
    end

    // random frames over many grid shapes and idling modes
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_TARGET || phase < 8) begin
      mode = (phase == 0) ? 0 : phase % 4;
      case (mode)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 55; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 55; end
        default: begin send_gap_pct = 6;  stall_pct = 6;  end
      endcase
      case (phase)
        0:       begin rows_w = 2047; cols_w = 1;  end  // clamps to the tallest grid
        1:       begin rows_w = 2;    cols_w = 63; end  // clamps to the widest grid
        2:       begin rows_w = 1;    cols_w = 32; end
        3:       begin rows_w = 3;    cols_w = 32; end
        default: begin
          rows_w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
          case ($urandom_range(9))
            0:       cols_w = 0;
            1:       cols_w = $urandom_range(33, 63);
            2:       cols_w = $urandom_range(9, 32);
            default: cols_w = $urandom_range(1, 8);
          endcase
        end
      endcase
      write_register(REG_NUM_ROWS, rows_w);
      write_register(REG_NUM_COLS, cols_w);
      fsize = clamp_size(rows_w, GRID_ROWS) * clamp_size(cols_w, GRID_COLS);
      // the tallest grid is only started; the next register write restarts it
      if (phase == 0) fsize = OPEN_CELLS;
      nframes = (phase <= 3) ? 1 : $urandom_range(1, 2);

      for (int f = 0; f < nframes; f++) begin
        mode = $urandom_range(2);
        for (int k = 0; k < fsize; k++) begin
          // once, let the output drain completely in the middle of a frame
          if (phase == 5 && f == 0 && k == fsize / 2) hold_input(0);
          push_cell(rand_height(mode), 1'b0, 1'b0, '0, '0);
          random_sent++;
        end
      end
      // sometimes leave a frame unfinished; the next register write restarts it
      if (phase >= 4 && fsize > 1 && $urandom_range(3) == 0) begin
        cut = $urandom_range(1, fsize - 1);
        for (int k = 0; k < cut; k++) begin
          push_cell(rand_height(0), 1'b0, 1'b0, '0, '0);
          random_sent++;
        end
      end
      phase++;
    end

    hold_input(2 * GRID_COLS);
    $display("Sent %0d heights (%0d random) over %0d random grid setups, %0d peaks checked.",
             heights_sent, random_sent, phase, peaks_seen);
    $display("Covered clamped sizes, restarts mid-frame and all four idling modes.");
    if (fail_count == 0) begin
      $display("grid_local_peak_finder test passed");
    end else begin
      $display("%0d errors", fail_count);
      $display("grid_local_peak_finder test failed");
    end
    $finish;
  end

endmodule
